/* hw/rtl/pfda_pkg.sv */
`default_nettype none
package pfda_pkg;

   // default configuration
   localparam int FRAME_COUNT_DEF     = 32;
   localparam int DIR_COUNT_DEF       = 4;
   localparam int FRAME_SIZE_LOG2_DEF = 22;

   // directory geometry and entry layout
   localparam int          ENTRIES     = 1024;
   localparam int          IDX_W       = 10;
   localparam int          ENTRY_W     = 14;
   localparam int          VA_SHIFT    = 22;
   localparam int          E_PRESENT   = 10;
   localparam logic [9:0]  KERNEL_HIGH = 10'h300;
   localparam logic [13:0] USER_ENTRY  = 14'h3C00;  // present, write, user, 4 MiB
   localparam logic [13:0] KERN_ENTRY  = 14'h2C00;  // present, write, 4 MiB

   typedef enum logic [2:0] {
      CMD_CHECK  = 3'd0,
      CMD_MAP    = 3'd1,
      CMD_UNMAP  = 3'd2,
      CMD_CREATE = 3'd3,
      CMD_FREE   = 3'd4
   } cmd_type;

   typedef enum logic [4:0] {
      DP_NOP,
      DP_CLEAR,
      DP_LATCH,
      DP_CHECK,
      DP_CNT_RESET,
      DP_CNT_INC,
      DP_MAP_RD,
      DP_MAP_TAKE,
      DP_UNMAP_RD,
      DP_FETCH,
      DP_RELEASE,
      DP_FREE_START,
      DP_FREE_RD,
      DP_FREE_KCLR,
      DP_FREE_DONE,
      DP_CREATE_TAKE,
      DP_CREATE_W2,
      DP_RSP_LOAD
   } dp_op_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_MAP_RD,
      ST_MAP_CHK,
      ST_UNMAP_CHK,
      ST_REL,
      ST_FREE_RD,
      ST_FREE_CHK,
      ST_FREE_NEXT,
      ST_CREATE,
      ST_CREATE_W2,
      ST_DONE
   } state_type;

   typedef struct packed {
      dp_op_type op;
   } dp_ctrl_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic       dvalid;
      logic       frame_free;
      logic       present;
      logic       last_frame;
      logic       last_entry;
      logic       last_dir;
      logic       kernel_idx;
      logic       dir_unused;
      logic       clear_last;
      logic       rsp_blocked;
   } dp_status_type;

endpackage
`default_nettype wire

/* hw/rtl/pfda_ram.sv */
`default_nettype none
module pfda_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output      logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule
`default_nettype wire

/* hw/rtl/pfda_ctrl.sv */
`default_nettype none
module pfda_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output      logic                    req_tready,
   input  wire pfda_pkg::dp_status_type stat,
   output      pfda_pkg::dp_ctrl_type   ctrl
);
   pfda_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pfda_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pfda_pkg::ST_CLEAR: if (stat.clear_last) state_in = pfda_pkg::ST_IDLE;
         pfda_pkg::ST_IDLE: if (req_tvalid) state_in = pfda_pkg::ST_DISPATCH;
         pfda_pkg::ST_DISPATCH: begin
            case (stat.cmd)
               pfda_pkg::CMD_MAP:
                  state_in = stat.dvalid ? pfda_pkg::ST_MAP_RD : pfda_pkg::ST_DONE;
               pfda_pkg::CMD_UNMAP:
                  state_in = stat.dvalid ? pfda_pkg::ST_UNMAP_CHK : pfda_pkg::ST_DONE;
               pfda_pkg::CMD_CREATE: state_in = pfda_pkg::ST_CREATE;
               pfda_pkg::CMD_FREE:
                  state_in = stat.dvalid ? pfda_pkg::ST_FREE_RD : pfda_pkg::ST_DONE;
               default: state_in = pfda_pkg::ST_DONE;
            endcase
         end
         pfda_pkg::ST_MAP_RD: state_in = pfda_pkg::ST_MAP_CHK;
         pfda_pkg::ST_MAP_CHK: begin
            if (stat.frame_free || stat.last_frame) state_in = pfda_pkg::ST_DONE;
            else state_in = pfda_pkg::ST_MAP_RD;
         end
         pfda_pkg::ST_UNMAP_CHK:
            state_in = stat.present ? pfda_pkg::ST_REL : pfda_pkg::ST_DONE;
         pfda_pkg::ST_REL: begin
            state_in = (stat.cmd == pfda_pkg::CMD_UNMAP) ? pfda_pkg::ST_DONE
                                                          : pfda_pkg::ST_FREE_NEXT;
         end
         pfda_pkg::ST_FREE_RD: state_in = pfda_pkg::ST_FREE_CHK;
         pfda_pkg::ST_FREE_CHK: begin
            if (!stat.kernel_idx && stat.present) state_in = pfda_pkg::ST_REL;
            else state_in = pfda_pkg::ST_FREE_NEXT;
         end
         pfda_pkg::ST_FREE_NEXT:
            state_in = stat.last_entry ? pfda_pkg::ST_DONE : pfda_pkg::ST_FREE_RD;
         pfda_pkg::ST_CREATE: begin
            if (stat.dir_unused) state_in = pfda_pkg::ST_CREATE_W2;
            else if (stat.last_dir) state_in = pfda_pkg::ST_DONE;
         end
         pfda_pkg::ST_CREATE_W2: state_in = pfda_pkg::ST_DONE;
         pfda_pkg::ST_DONE: if (!stat.rsp_blocked) state_in = pfda_pkg::ST_IDLE;
         default: state_in = pfda_pkg::ST_CLEAR;
      endcase
   end

   // datapath commands
   always_comb begin
      ctrl.op    = pfda_pkg::DP_NOP;
      req_tready = 1'b0;
      case (state_ff)
         pfda_pkg::ST_CLEAR: ctrl.op = pfda_pkg::DP_CLEAR;
         pfda_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) ctrl.op = pfda_pkg::DP_LATCH;
         end
         pfda_pkg::ST_DISPATCH: begin
            case (stat.cmd)
               pfda_pkg::CMD_CHECK: ctrl.op = pfda_pkg::DP_CHECK;
               pfda_pkg::CMD_MAP:
                  ctrl.op = stat.dvalid ? pfda_pkg::DP_CNT_RESET : pfda_pkg::DP_NOP;
               pfda_pkg::CMD_UNMAP:
                  ctrl.op = stat.dvalid ? pfda_pkg::DP_UNMAP_RD : pfda_pkg::DP_NOP;
               pfda_pkg::CMD_CREATE: ctrl.op = pfda_pkg::DP_CNT_RESET;
               pfda_pkg::CMD_FREE:
                  ctrl.op = stat.dvalid ? pfda_pkg::DP_FREE_START : pfda_pkg::DP_NOP;
               default: ctrl.op = pfda_pkg::DP_NOP;
            endcase
         end
         pfda_pkg::ST_MAP_RD: ctrl.op = pfda_pkg::DP_MAP_RD;
         pfda_pkg::ST_MAP_CHK: begin
            if (stat.frame_free) ctrl.op = pfda_pkg::DP_MAP_TAKE;
            else if (!stat.last_frame) ctrl.op = pfda_pkg::DP_CNT_INC;
         end
         pfda_pkg::ST_UNMAP_CHK: if (stat.present) ctrl.op = pfda_pkg::DP_FETCH;
         pfda_pkg::ST_REL: ctrl.op = pfda_pkg::DP_RELEASE;
         pfda_pkg::ST_FREE_RD: ctrl.op = pfda_pkg::DP_FREE_RD;
         pfda_pkg::ST_FREE_CHK: begin
            if (stat.kernel_idx) ctrl.op = pfda_pkg::DP_FREE_KCLR;
            else if (stat.present) ctrl.op = pfda_pkg::DP_FETCH;
         end
         pfda_pkg::ST_FREE_NEXT:
            ctrl.op = stat.last_entry ? pfda_pkg::DP_FREE_DONE : pfda_pkg::DP_CNT_INC;
         pfda_pkg::ST_CREATE: begin
            if (stat.dir_unused) ctrl.op = pfda_pkg::DP_CREATE_TAKE;
            else if (!stat.last_dir) ctrl.op = pfda_pkg::DP_CNT_INC;
         end
         pfda_pkg::ST_CREATE_W2: ctrl.op = pfda_pkg::DP_CREATE_W2;
         pfda_pkg::ST_DONE: if (!stat.rsp_blocked) ctrl.op = pfda_pkg::DP_RSP_LOAD;
         default: ctrl.op = pfda_pkg::DP_NOP;
      endcase
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready && req_tvalid |=> state_ff == pfda_pkg::ST_DISPATCH)
      else $error("accepted transaction not dispatched");
   a_done_blocked: assert property (@(posedge clock) disable iff (reset)
      state_ff == pfda_pkg::ST_DONE && stat.rsp_blocked |=> state_ff == pfda_pkg::ST_DONE)
      else $error("left done state with response slot full");
   a_clear_once: assert property (@(posedge clock) disable iff (reset)
      state_ff != pfda_pkg::ST_CLEAR |=> state_ff != pfda_pkg::ST_CLEAR)
      else $error("clearing pass re-entered");
endmodule
`default_nettype wire

/* hw/rtl/pfda_dp.sv */
`default_nettype none
module pfda_dp #(
   parameter int FRAME_COUNT     = pfda_pkg::FRAME_COUNT_DEF,
   parameter int DIR_COUNT       = pfda_pkg::DIR_COUNT_DEF,
   parameter int FRAME_SIZE_LOG2 = pfda_pkg::FRAME_SIZE_LOG2_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic [2:0]              req_cmd,
   input  wire logic [1:0]              req_dir,
   input  wire logic [31:0]             req_va,
   input  wire logic [31:0]             req_amount,
   output      logic                    rsp_tvalid,
   input  wire logic                    rsp_tready,
   output      logic [31:0]             rsp_tdata,
   input  wire pfda_pkg::dp_ctrl_type   ctrl,
   output      pfda_pkg::dp_status_type stat
);
   localparam int DIR_DEPTH = DIR_COUNT * pfda_pkg::ENTRIES;
   localparam int AW        = $clog2(DIR_DEPTH);
   localparam int DW        = (DIR_COUNT > 1) ? $clog2(DIR_COUNT) : 1;
   localparam int FW        = $clog2(FRAME_COUNT);
   localparam int CF        = $clog2(FRAME_COUNT + 1);

   logic [2:0]         cmd_ff;
   logic [1:0]         dir_ff;
   logic [9:0]         idx_ff;
   logic [31:0]        amount_ff;
   logic [9:0]         frame_ff, frame_in;
   logic [AW-1:0]      cnt_ff, cnt_in;
   logic [CF-1:0]      count_ff, count_in;
   logic [DIR_COUNT-1:0] in_use_ff, in_use_in;
   logic               res_ok_ff, res_ok_in, res_flush_ff, res_flush_in;
   logic [1:0]         res_dir_ff, res_dir_in;
   logic [4:0]         res_frame_ff, res_frame_in;
   logic [9:0]         res_fidx_ff, res_fidx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_data_ff;

   logic               dir_we, frame_we, frame_wdata, frame_rdata;
   logic [AW-1:0]      dir_addr;
   logic [FW-1:0]      frame_addr;
   logic [13:0]        dir_wdata, dir_rdata;
   logic [DW-1:0]      d_sel, cnt_dir;
   logic [7:0]         dir_wide, cnt_wide;
   logic [9:0]         ent_idx;
   logic [32:0]        need;
   logic               rel_ok;
   logic [10:0]        count_wide;

   assign dir_wide  = 8'(dir_ff);
   assign d_sel     = dir_wide[DW-1:0];
   assign cnt_wide  = cnt_ff[7:0];
   assign cnt_dir   = cnt_wide[DW-1:0];
   assign ent_idx   = (cmd_ff == pfda_pkg::CMD_FREE) ? cnt_ff[9:0] : idx_ff;
   assign need      = ({1'b0, amount_ff} + 33'((64'd1 << FRAME_SIZE_LOG2) - 64'd1))
                      >> FRAME_SIZE_LOG2;
   assign rel_ok    = (frame_ff != 10'd0) && (11'(frame_ff) < 11'(FRAME_COUNT))
                      && frame_rdata;
   assign count_wide = 11'(count_ff);

   // memory ports
   always_comb begin
      dir_we      = 1'b0;
      dir_wdata   = '0;
      dir_addr    = AW'({d_sel, ent_idx});
      frame_we    = 1'b0;
      frame_wdata = 1'b0;
      frame_addr  = cnt_ff[FW-1:0];
      case (ctrl.op)
         pfda_pkg::DP_CLEAR: begin
            dir_addr    = cnt_ff;
            dir_we      = 1'b1;
            frame_we    = 32'(cnt_ff) < FRAME_COUNT;
            frame_wdata = (cnt_ff == '0);
         end
         pfda_pkg::DP_MAP_TAKE: begin
            frame_we    = 1'b1;
            frame_wdata = 1'b1;
            dir_we      = 1'b1;
            dir_wdata   = pfda_pkg::USER_ENTRY | 14'(cnt_ff[FW-1:0]);
         end
         pfda_pkg::DP_FETCH: frame_addr = dir_rdata[FW-1:0];
         pfda_pkg::DP_RELEASE: begin
            frame_addr = frame_ff[FW-1:0];
            frame_we   = rel_ok;
            dir_we     = 1'b1;
         end
         pfda_pkg::DP_FREE_KCLR: dir_we = 1'b1;
         pfda_pkg::DP_CREATE_TAKE: begin
            dir_addr  = AW'({cnt_dir, 10'd0});
            dir_we    = 1'b1;
            dir_wdata = pfda_pkg::KERN_ENTRY;
         end
         pfda_pkg::DP_CREATE_W2: begin
            dir_addr  = AW'({cnt_dir, pfda_pkg::KERNEL_HIGH});
            dir_we    = 1'b1;
            dir_wdata = pfda_pkg::KERN_ENTRY;
         end
         default: ;
      endcase
   end

   pfda_ram #(.WIDTH(pfda_pkg::ENTRY_W), .DEPTH(DIR_DEPTH)) u_dir_ram (
      .clock(clock), .we(dir_we), .addr(dir_addr), .wdata(dir_wdata), .rdata(dir_rdata)
   );

   pfda_ram #(.WIDTH(1), .DEPTH(FRAME_COUNT)) u_frame_ram (
      .clock(clock), .we(frame_we), .addr(frame_addr), .wdata(frame_wdata),
      .rdata(frame_rdata)
   );

   // register updates
   always_comb begin
      cnt_in       = cnt_ff;
      count_in     = count_ff;
      in_use_in    = in_use_ff;
      frame_in     = frame_ff;
      res_ok_in    = res_ok_ff;
      res_dir_in   = res_dir_ff;
      res_frame_in = res_frame_ff;
      res_flush_in = res_flush_ff;
      res_fidx_in  = res_fidx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (ctrl.op)
         pfda_pkg::DP_CLEAR, pfda_pkg::DP_CNT_INC: cnt_in = cnt_ff + AW'(1);
         pfda_pkg::DP_LATCH: begin
            res_ok_in    = 1'b0;
            res_dir_in   = '0;
            res_frame_in = '0;
            res_flush_in = 1'b0;
            res_fidx_in  = '0;
         end
         pfda_pkg::DP_CHECK: res_ok_in = (33'(count_ff) >= need);
         pfda_pkg::DP_CNT_RESET: cnt_in = '0;
         pfda_pkg::DP_MAP_TAKE: begin
            count_in     = count_ff - CF'(1);
            res_ok_in    = 1'b1;
            res_frame_in = cnt_ff[4:0];
            res_flush_in = 1'b1;
            res_fidx_in  = idx_ff;
         end
         pfda_pkg::DP_FETCH: frame_in = dir_rdata[9:0];
         pfda_pkg::DP_RELEASE: begin
            if (rel_ok) count_in = count_ff + CF'(1);
            if (cmd_ff == pfda_pkg::CMD_UNMAP) begin
               res_ok_in    = 1'b1;
               res_frame_in = frame_ff[4:0];
               res_flush_in = 1'b1;
               res_fidx_in  = idx_ff;
            end
         end
         pfda_pkg::DP_FREE_START: begin
            in_use_in[d_sel] = 1'b0;
            cnt_in           = '0;
         end
         pfda_pkg::DP_FREE_DONE: res_ok_in = 1'b1;
         pfda_pkg::DP_CREATE_TAKE: in_use_in[cnt_dir] = 1'b1;
         pfda_pkg::DP_CREATE_W2: begin
            res_ok_in  = 1'b1;
            res_dir_in = cnt_ff[1:0];
         end
         pfda_pkg::DP_RSP_LOAD: rsp_valid_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         count_ff     <= CF'(FRAME_COUNT - 1);
         in_use_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         count_ff     <= count_in;
         in_use_ff    <= in_use_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.op == pfda_pkg::DP_LATCH) begin
         cmd_ff    <= req_cmd;
         dir_ff    <= req_dir;
         idx_ff    <= req_va[pfda_pkg::VA_SHIFT +: pfda_pkg::IDX_W];
         amount_ff <= req_amount;
      end
      frame_ff     <= frame_in;
      res_ok_ff    <= res_ok_in;
      res_dir_ff   <= res_dir_in;
      res_frame_ff <= res_frame_in;
      res_flush_ff <= res_flush_in;
      res_fidx_ff  <= res_fidx_in;
      if (ctrl.op == pfda_pkg::DP_RSP_LOAD) begin
         rsp_data_ff <= {7'd0, res_fidx_ff, res_flush_ff, count_wide[5:0],
                         res_frame_ff, res_dir_ff, res_ok_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      stat.cmd         = cmd_ff;
      stat.dvalid      = 7'(dir_ff) < 7'(DIR_COUNT);
      stat.frame_free  = !frame_rdata;
      stat.present     = dir_rdata[pfda_pkg::E_PRESENT];
      stat.last_frame  = 32'(cnt_ff) == FRAME_COUNT - 1;
      stat.last_entry  = cnt_ff[9:0] == 10'h3FF;
      stat.last_dir    = 32'(cnt_ff) == DIR_COUNT - 1;
      stat.kernel_idx  = (cnt_ff[9:0] == 10'd0) || (cnt_ff[9:0] == pfda_pkg::KERNEL_HIGH);
      stat.dir_unused  = !in_use_ff[cnt_dir];
      stat.clear_last  = 32'(cnt_ff) == DIR_DEPTH - 1;
      stat.rsp_blocked = rsp_valid_ff && !rsp_tready;
   end

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= FRAME_COUNT - 1)
      else $error("free frame count above pool size");
   a_kernel_frame: assert property (@(posedge clock) disable iff (reset)
      frame_we && !frame_wdata |-> frame_addr != '0)
      else $error("kernel frame released");
   a_rsp_slot: assert property (@(posedge clock) disable iff (reset)
      ctrl.op == pfda_pkg::DP_RSP_LOAD |-> !(rsp_valid_ff && !rsp_tready))
      else $error("response overwritten");
endmodule
`default_nettype wire

/* hw/rtl/page_frame_and_directory_allocator.sv */
`default_nettype none
// Page frame and directory allocator: one command per req transaction, one
// rsp transaction each. Commands: check amount, map (lowest free frame),
// unmap, create directory (lowest unused), free directory. After reset the
// block runs a clearing pass over all DIR_COUNT*1024 directory entries
// (4096 at defaults) before it takes the first command. Commands are
// handled one at a time by a controller sequencing a single-port entry RAM
// and frame bitmap RAM: map scans the frames in turn, create scans the
// directories, and free directory walks all 1024 entries of the directory.
// Results wait in an output register, so the next command can be accepted
// meanwhile.
module page_frame_and_directory_allocator #(
   parameter int FRAME_COUNT     = pfda_pkg::FRAME_COUNT_DEF,
   parameter int DIR_COUNT       = pfda_pkg::DIR_COUNT_DEF,
   parameter int FRAME_SIZE_LOG2 = pfda_pkg::FRAME_SIZE_LOG2_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [71:0] req_tdata,  // dir_id[1:0], virt_addr[33:2], amount[65:34]
   input  wire logic [2:0]  req_tuser,  // cmd[2:0]
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [31:0] rsp_tdata   // ok[0], dir_out[2:1], frame_out[7:3],
                                        // free_frames[13:8], tlb_flush[14],
                                        // flush_index[24:15]
);
   pfda_pkg::dp_ctrl_type   ctrl;
   pfda_pkg::dp_status_type stat;
   logic [5:0]              unused_pad;

   // upper pad bits of the request carry nothing
   assign unused_pad = req_tdata[71:66];

   pfda_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .stat(stat), .ctrl(ctrl)
   );

   pfda_dp #(
      .FRAME_COUNT(FRAME_COUNT), .DIR_COUNT(DIR_COUNT),
      .FRAME_SIZE_LOG2(FRAME_SIZE_LOG2)
   ) u_dp (
      .clock(clock), .reset(reset),
      .req_cmd(req_tuser), .req_dir(req_tdata[1:0]),
      .req_va(req_tdata[33:2]), .req_amount(req_tdata[65:34] | 32'(unused_pad & 6'd0)),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .ctrl(ctrl), .stat(stat)
   );
endmodule
`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb;

   // commands past the last defined one: the block must refuse them
   localparam logic [2:0] CMD_UNKNOWN_FIRST = 3'd5;
   localparam logic [2:0] CMD_UNKNOWN_LAST  = 3'd7;
   localparam int         FRAMES            = pfda_pkg::FRAME_COUNT_DEF;
   localparam int         DIRS              = pfda_pkg::DIR_COUNT_DEF;
   localparam int         RANDOM_ITEMS      = 515;

   // packed from the top bit down, so ok lands in bit 0
   typedef struct packed {
      logic [9:0] flush_index;
      logic       tlb_flush;
      logic [5:0] free_frames;
      logic [4:0] frame_out;
      logic [1:0] dir_out;
      logic       ok;
   } alloc_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;   // dir_id[1:0], virt_addr[33:2], amount[65:34]
   logic [2:0]  req_tuser;   // cmd[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // ok[0], dir_out[2:1], frame_out[7:3], free_frames[13:8],
                             // tlb_flush[14], flush_index[24:15]

   // shadow copy of the allocator state
   logic                          frame_taken [FRAMES];
   logic [5:0]                    free_frames_q;
   logic                          dir_taken [DIRS];
   logic [pfda_pkg::ENTRY_W-1:0]  dir_table [DIRS][pfda_pkg::ENTRIES];

   alloc_result_type pending_results[$];
   int               error_count;
   int               checked_count;
   int               cmd_count [8];
   int               rsp_stall_left;
   bit               quiet_phase;   // no new idle stretches on either side while set

   page_frame_and_directory_allocator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   task automatic report(input string what, input int got, input int want);
      $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
      error_count++;
   endtask

   function automatic void clear_shadow();
      for (int f = 0; f < FRAMES; f++) frame_taken[f] = (f == 0);
      free_frames_q = 6'(FRAMES - 1);
      for (int d = 0; d < DIRS; d++) begin
         dir_taken[d] = 1'b0;
         for (int e = 0; e < pfda_pkg::ENTRIES; e++) dir_table[d][e] = '0;
      end
   endfunction

   // clear an entry and return its frame to the pool unless it is the kernel frame
   function automatic logic [9:0] drop_entry(input int d, input int e);
      logic [9:0] f;
      f = dir_table[d][e][9:0];
      if (f != 0 && f < FRAMES && frame_taken[f]) begin
         frame_taken[f] = 1'b0;
         free_frames_q++;
      end
      dir_table[d][e] = '0;
      return f;
   endfunction

   function automatic alloc_result_type run_allocator(input logic [2:0] cmd,
                                                      input logic [1:0] d,
                                                      input logic [31:0] va,
                                                      input logic [31:0] amount);
      alloc_result_type r;
      logic [9:0]       idx;
      logic [32:0]      frames_needed;
      r = '0;
      idx = va[31:pfda_pkg::VA_SHIFT];
      case (cmd)
         pfda_pkg::CMD_CHECK: begin
            frames_needed = ({1'b0, amount} + 33'h3F_FFFF) >> pfda_pkg::FRAME_SIZE_LOG2_DEF;
            r.ok = ({27'd0, free_frames_q} >= frames_needed);
         end
         pfda_pkg::CMD_MAP: begin
            for (int f = 0; f < FRAMES; f++) begin
               if (!frame_taken[f]) begin
                  frame_taken[f] = 1'b1;
                  free_frames_q--;
                  dir_table[d][idx] = pfda_pkg::USER_ENTRY | pfda_pkg::ENTRY_W'(f);
                  r.ok = 1'b1;
                  r.frame_out = 5'(f);
                  r.tlb_flush = 1'b1;
                  r.flush_index = idx;
                  break;
               end
            end
         end
         pfda_pkg::CMD_UNMAP: begin
            if (dir_table[d][idx][pfda_pkg::E_PRESENT]) begin
               r.frame_out = 5'(drop_entry(d, idx));
               r.ok = 1'b1;
               r.tlb_flush = 1'b1;
               r.flush_index = idx;
            end
         end
         pfda_pkg::CMD_CREATE: begin
            for (int i = 0; i < DIRS; i++) begin
               if (!dir_taken[i]) begin
                  dir_taken[i] = 1'b1;
                  dir_table[i][0] = pfda_pkg::KERN_ENTRY;
                  dir_table[i][pfda_pkg::KERNEL_HIGH] = pfda_pkg::KERN_ENTRY;
                  r.ok = 1'b1;
                  r.dir_out = 2'(i);
                  break;
               end
            end
         end
         pfda_pkg::CMD_FREE: begin
            dir_taken[d] = 1'b0;
            for (int e = 0; e < pfda_pkg::ENTRIES; e++) begin
               if (e == 0 || e == pfda_pkg::KERNEL_HIGH) dir_table[d][e] = '0;
               else if (dir_table[d][e][pfda_pkg::E_PRESENT]) void'(drop_entry(d, e));
            end
            r.ok = 1'b1;
         end
         default: ;
      endcase
      r.free_frames = free_frames_q;
      return r;
   endfunction

   // random idle length: mostly none or short, now and then long
   function automatic int idle_cycles();
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet_phase || roll < 60) return 0;
      if (roll < 94) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // present one command at a falling edge; hold it until the handshake completes
   task automatic send_cmd(input logic [2:0] cmd, input logic [1:0] d,
                           input logic [31:0] va, input logic [31:0] amount);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {6'd0, amount, va, d};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(run_allocator(cmd, d, va, amount));
      cmd_count[cmd]++;
      @(negedge clock);
      gap = idle_cycles();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // hold off the sender until every outstanding result has been returned
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   function automatic logic [31:0] va_at(input logic [9:0] idx);
      return {idx, 22'($urandom)};
   endfunction

   task automatic test_check_amounts();
      send_cmd(pfda_pkg::CMD_CHECK, 2'd0, '0, 32'd0);
      send_cmd(pfda_pkg::CMD_CHECK, 2'd3, '1, 32'd1);
      send_cmd(pfda_pkg::CMD_CHECK, 2'd0, '0, 32'h0040_0000);
      send_cmd(pfda_pkg::CMD_CHECK, 2'd0, '0, 32'h7C00_0000);   // 496 frames' worth, more than are free
      send_cmd(pfda_pkg::CMD_CHECK, 2'd0, '0, 32'h7C00_0001);   // one byte more
      send_cmd(pfda_pkg::CMD_CHECK, 2'd0, '0, 32'hFFFF_FFFF);   // round-up must not wrap
   endtask

   task automatic test_map_unmap();
      send_cmd(pfda_pkg::CMD_CREATE, 2'd0, '0, '0);
      send_cmd(pfda_pkg::CMD_MAP, 2'd0, 32'hFFFF_FFFF, '1);
      send_cmd(pfda_pkg::CMD_MAP, 2'd0, 32'h0000_0000, '0);      // overwrite kernel entry 0
      send_cmd(pfda_pkg::CMD_MAP, 2'd0, 32'hFFC0_0000, '0);      // overwrite, old frame leaks
      send_cmd(pfda_pkg::CMD_UNMAP, 2'd0, 32'hFFFF_FFFF, '0);
      send_cmd(pfda_pkg::CMD_UNMAP, 2'd0, 32'hFFC0_0000, '0);    // entry now absent
      send_cmd(pfda_pkg::CMD_UNMAP, 2'd0, 32'hC000_0000, '0);    // kernel frame stays used
      send_cmd(pfda_pkg::CMD_MAP, 2'd2, 32'h1234_5678, '0);      // directory not in use
      send_cmd(pfda_pkg::CMD_UNMAP, 2'd2, 32'h1234_5678, '0);
   endtask

   task automatic test_create_free();
      for (int i = 0; i < DIRS; i++) send_cmd(pfda_pkg::CMD_CREATE, '0, '0, '0);  // last fails
      send_cmd(pfda_pkg::CMD_MAP, 2'd3, 32'h4000_0000, '0);
      send_cmd(pfda_pkg::CMD_FREE, 2'd3, '0, '0);
      send_cmd(pfda_pkg::CMD_FREE, 2'd3, '0, '0);                 // already unused
      send_cmd(pfda_pkg::CMD_CREATE, '0, '0, '0);
   endtask

   task automatic test_unknown_cmds();
      for (logic [3:0] c = CMD_UNKNOWN_FIRST; c <= CMD_UNKNOWN_LAST; c++)
         send_cmd(c[2:0], 2'(c), '1, '1);
   endtask

   // mostly map/unmap on a few hot entries so frames run out and come back
   task automatic test_random_traffic();
      logic [9:0]  hot [6];
      logic [9:0]  idx;
      logic [31:0] amount;
      int          roll;
      hot[0] = 10'd0;
      hot[1] = pfda_pkg::KERNEL_HIGH;
      hot[2] = 10'h3FF;
      for (int h = 3; h < 6; h++) hot[h] = 10'($urandom);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) drain_results();
         quiet_phase = (n >= RANDOM_ITEMS / 2 && n < RANDOM_ITEMS / 2 + 60);
         roll = $urandom_range(0, 99);
         idx = ($urandom_range(0, 3) != 0) ? hot[$urandom_range(0, 5)] : 10'($urandom);
         case ($urandom_range(0, 3))
            0: amount = $urandom;
            1: amount = $urandom_range(0, 32'h0800_0000);
            2: amount = 32'($urandom_range(0, 32)) << pfda_pkg::FRAME_SIZE_LOG2_DEF;
            default: amount = $urandom >> $urandom_range(0, 31);
         endcase
         if (roll < 42)
            send_cmd(pfda_pkg::CMD_MAP, 2'($urandom), va_at(idx), amount);
         else if (roll < 70)
            send_cmd(pfda_pkg::CMD_UNMAP, 2'($urandom), va_at(idx), amount);
         else if (roll < 84)
            send_cmd(pfda_pkg::CMD_CHECK, 2'($urandom), $urandom, amount);
         else if (roll < 91)
            send_cmd(pfda_pkg::CMD_CREATE, 2'($urandom), $urandom, amount);
         else if (roll < 97)
            send_cmd(pfda_pkg::CMD_FREE, 2'($urandom), $urandom, amount);
         else send_cmd(3'($urandom_range(CMD_UNKNOWN_FIRST, CMD_UNKNOWN_LAST)),
                       2'($urandom), $urandom, amount);
      end
      quiet_phase = 1'b0;
   endtask

   // receiver: stall at random, in short and occasional long stretches
   always @(negedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall_left <= rsp_stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (!quiet_phase && $urandom_range(0, 99) < 15)
            rsp_stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                          : $urandom_range(1, 3);
      end
   end

   // compare every returned result with the oldest prediction
   always @(posedge clock) begin : result_check
      alloc_result_type got;
      alloc_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = alloc_result_type'(rsp_tdata[24:0]);
         if (pending_results.size() == 0) begin
            report("unexpected result", int'(got), 0);
         end else begin
            want = pending_results.pop_front();
            checked_count++;
            if (got.ok != want.ok) report("ok", got.ok, want.ok);
            if (got.dir_out != want.dir_out) report("dir_out", got.dir_out, want.dir_out);
            if (got.frame_out != want.frame_out)
               report("frame_out", got.frame_out, want.frame_out);
            if (got.free_frames != want.free_frames)
               report("free_frames", got.free_frames, want.free_frames);
            if (got.tlb_flush != want.tlb_flush)
               report("tlb_flush", got.tlb_flush, want.tlb_flush);
            if (got.flush_index != want.flush_index)
               report("flush_index", got.flush_index, want.flush_index);
         end
      end
   end

   initial begin
      #40_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      error_count = 0;
      checked_count = 0;
      rsp_stall_left = 0;
      quiet_phase = 1'b0;
      foreach (cmd_count[i]) cmd_count[i] = 0;
      clear_shadow();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_check_amounts();
      test_map_unmap();
      test_create_free();
      test_unknown_cmds();
      test_random_traffic();

      drain_results();
      repeat (100) @(negedge clock);

      $display("Covered %0d check, %0d map, %0d unmap, %0d create, %0d free directory commands",
               cmd_count[pfda_pkg::CMD_CHECK], cmd_count[pfda_pkg::CMD_MAP],
               cmd_count[pfda_pkg::CMD_UNMAP], cmd_count[pfda_pkg::CMD_CREATE],
               cmd_count[pfda_pkg::CMD_FREE]);
      $display("plus %0d unknown commands; %0d results compared, %0d mismatches",
               cmd_count[5] + cmd_count[6] + cmd_count[7], checked_count, error_count);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
`default_nettype wire

/* sim.f */
hw/rtl/pfda_pkg.sv
hw/rtl/pfda_ram.sv
hw/rtl/pfda_ctrl.sv
hw/rtl/pfda_dp.sv
hw/rtl/page_frame_and_directory_allocator.sv
bench/tb.sv
